/* design/button_edge_latch_assert.svh */
// Assertion macros used by the button edge latch checker.
`ifndef BUTTON_EDGE_LATCH_ASSERT_SVH
`define BUTTON_EDGE_LATCH_ASSERT_SVH

// Property checked while reset is low.
`define BEL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("button_edge_latch check failed");

// Property checked on every edge, reset included.
`define BEL_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("button_edge_latch check failed");

`endif

/* design/bel_pkg.sv */
// Types and constants of the button edge latch.
package bel_pkg;

   localparam int NumButtonsDefault = 32;
   localparam int WordWidth         = 32;
   localparam int ModeWidth         = 3;
   localparam int IndexWidth        = 5;
   localparam int ReqDataWidth      = 8;
   localparam int ResultWidth       = 3 * WordWidth + 1;
   localparam int RspDataWidth      = 104;

   // Operation codes carried on req_tuser.
   typedef enum logic [ModeWidth-1:0] {
      MODE_KEY        = 3'd0,
      MODE_SYNTHETIC  = 3'd1,
      MODE_READ_STAT  = 3'd2,
      MODE_READ_KEY   = 3'd3,
      MODE_READ_PEND  = 3'd4,
      MODE_CLEAR_ALL  = 3'd5,
      MODE_CLEAR_SYN  = 3'd6,
      MODE_RESET      = 3'd7
   } mode_type;

   // One result word, first member in the top bits.
   typedef struct packed {
      logic                 event_pending;
      logic [WordWidth-1:0] release_edges;
      logic [WordWidth-1:0] press_edges;
      logic [WordWidth-1:0] status_bits;
   } result_type;

endpackage

/* design/button_edge_latch.sv */
// A word accepted into the input register passes through the update logic into the
// result register once the result slot is free or its result is being taken.
// Throughput: one word per cycle while the receiver keeps taking results, set by the
// single update stage between the input register and the result register.
// Reset (synchronous, active high) empties both stages and clears every
// button word and the pending flag.
module button_edge_latch #(
   parameter int NUM_BUTTONS = bel_pkg::NumButtonsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bel_pkg::ReqDataWidth-1:0]   req_tdata,  // [4:0] control_index, [5] key_down
   input  logic [bel_pkg::ModeWidth-1:0]      req_tuser,  // [2:0] mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bel_pkg::RspDataWidth-1:0]   rsp_tdata   // [31:0] status_bits,
                                                          // [63:32] press_edges,
                                                          // [95:64] release_edges,
                                                          // [96] event_pending
);

   logic                              in_valid_ff, in_valid_in;
   bel_pkg::mode_type                 in_mode_ff;
   logic [bel_pkg::IndexWidth-1:0]    in_index_ff;
   logic                              in_down_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   bel_pkg::result_type               rsp_ff, result;
   logic [NUM_BUTTONS-1:0]            held_ff, press_ff, release_ff, deferred_ff, synthetic_ff;
   logic [NUM_BUTTONS-1:0]            held_in, press_in, release_in, deferred_in, synthetic_in;
   logic                              pending_ff, pending_in;
   logic                              req_take, advance;

   // Handshake: the input stage moves on when the result slot is free or taken
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || !rsp_valid_ff || rsp_tready;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_mode_ff  <= bel_pkg::mode_type'(req_tuser);
         in_index_ff <= req_tdata[bel_pkg::IndexWidth-1:0];
         in_down_ff  <= req_tdata[bel_pkg::IndexWidth];
      end
   end

   bel_update #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_update (
      .mode          (in_mode_ff),
      .control_index (in_index_ff),
      .key_down      (in_down_ff),
      .held_cur      (held_ff),
      .press_cur     (press_ff),
      .release_cur   (release_ff),
      .deferred_cur  (deferred_ff),
      .synthetic_cur (synthetic_ff),
      .pending_cur   (pending_ff),
      .held_nxt      (held_in),
      .press_nxt     (press_in),
      .release_nxt   (release_in),
      .deferred_nxt  (deferred_in),
      .synthetic_nxt (synthetic_in),
      .pending_nxt   (pending_in),
      .result        (result)
   );

   // Button state, committed as a word leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         press_ff     <= '0;
         release_ff   <= '0;
         deferred_ff  <= '0;
         synthetic_ff <= '0;
         pending_ff   <= 1'b0;
      end else if (advance) begin
         held_ff      <= held_in;
         press_ff     <= press_in;
         release_ff   <= release_in;
         deferred_ff  <= deferred_in;
         synthetic_ff <= synthetic_in;
         pending_ff   <= pending_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(bel_pkg::RspDataWidth - bel_pkg::ResultWidth)'(0), rsp_ff};

endmodule

/* design/bel_update.sv */
// Next-state and result logic for one button latch operation.
module bel_update #(
   parameter int NUM_BUTTONS = bel_pkg::NumButtonsDefault
) (
   input  bel_pkg::mode_type                mode,
   input  logic [bel_pkg::IndexWidth-1:0]   control_index,
   input  logic                             key_down,
   input  logic [NUM_BUTTONS-1:0]           held_cur,
   input  logic [NUM_BUTTONS-1:0]           press_cur,
   input  logic [NUM_BUTTONS-1:0]           release_cur,
   input  logic [NUM_BUTTONS-1:0]           deferred_cur,
   input  logic [NUM_BUTTONS-1:0]           synthetic_cur,
   input  logic                             pending_cur,
   output logic [NUM_BUTTONS-1:0]           held_nxt,
   output logic [NUM_BUTTONS-1:0]           press_nxt,
   output logic [NUM_BUTTONS-1:0]           release_nxt,
   output logic [NUM_BUTTONS-1:0]           deferred_nxt,
   output logic [NUM_BUTTONS-1:0]           synthetic_nxt,
   output logic                             pending_nxt,
   output bel_pkg::result_type              result
);

   logic [NUM_BUTTONS-1:0] sel_bit;
   logic [NUM_BUTTONS-1:0] syn_release;
   logic                   report_before;

   // One-hot button select; indexes past the last button select nothing.
   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_sel
      assign sel_bit[i] = (control_index == bel_pkg::IndexWidth'(i));
   end

   assign syn_release = synthetic_cur & held_cur;

   // State update per operation
   always_comb begin
      held_nxt      = held_cur;
      press_nxt     = press_cur;
      release_nxt   = release_cur;
      deferred_nxt  = deferred_cur;
      synthetic_nxt = synthetic_cur;
      pending_nxt   = pending_cur;
      report_before = 1'b0;
      case (mode)
         bel_pkg::MODE_KEY, bel_pkg::MODE_SYNTHETIC: begin
            if (|sel_bit) begin
               if (mode == bel_pkg::MODE_SYNTHETIC) begin
                  synthetic_nxt = key_down ? (synthetic_cur | sel_bit)
                                           : (synthetic_cur & ~sel_bit);
               end
               if (key_down) begin
                  deferred_nxt = deferred_cur & ~sel_bit;
                  if ((held_cur & sel_bit) == '0) begin
                     press_nxt   = press_cur | sel_bit;
                     pending_nxt = 1'b1;
                  end
                  release_nxt = release_cur & ~sel_bit;
                  held_nxt    = held_cur | sel_bit;
               end else if ((held_cur & sel_bit) != '0) begin
                  // release before the press was read: hold it back
                  if ((press_cur & sel_bit) != '0) begin
                     deferred_nxt = deferred_cur | sel_bit;
                  end else begin
                     release_nxt = release_cur | sel_bit;
                     held_nxt    = held_cur & ~sel_bit;
                     pending_nxt = 1'b1;
                  end
               end
            end
         end
         bel_pkg::MODE_READ_STAT: begin
            report_before = 1'b1;
            press_nxt     = '0;
            release_nxt   = deferred_cur;
            if (deferred_cur != '0) begin
               held_nxt     = held_cur & ~deferred_cur;
               pending_nxt  = 1'b1;
               deferred_nxt = '0;
            end
         end
         bel_pkg::MODE_READ_KEY: begin
            report_before = 1'b1;
            if (deferred_cur != '0) begin
               release_nxt  = release_cur | deferred_cur;
               held_nxt     = held_cur & ~deferred_cur;
               pending_nxt  = 1'b1;
               deferred_nxt = '0;
            end
         end
         bel_pkg::MODE_READ_PEND: begin
            report_before = 1'b1;
            pending_nxt   = 1'b0;
         end
         bel_pkg::MODE_CLEAR_ALL: begin
            deferred_nxt = '0;
            if (held_cur != '0) begin
               release_nxt = release_cur | held_cur;
               held_nxt    = '0;
               pending_nxt = 1'b1;
            end
         end
         bel_pkg::MODE_CLEAR_SYN: begin
            synthetic_nxt = '0;
            if (syn_release != '0) begin
               release_nxt = release_cur | syn_release;
               held_nxt    = held_cur & ~syn_release;
               pending_nxt = 1'b1;
            end
         end
         default: begin
            held_nxt      = '0;
            press_nxt     = '0;
            release_nxt   = '0;
            deferred_nxt  = '0;
            synthetic_nxt = '0;
            pending_nxt   = 1'b0;
         end
      endcase
   end

   // Reads report the words before the access, everything else after
   always_comb begin
      if (report_before) begin
         result.status_bits   = bel_pkg::WordWidth'(held_cur);
         result.press_edges   = bel_pkg::WordWidth'(press_cur);
         result.release_edges = bel_pkg::WordWidth'(release_cur);
         result.event_pending = pending_cur;
      end else begin
         result.status_bits   = bel_pkg::WordWidth'(held_nxt);
         result.press_edges   = bel_pkg::WordWidth'(press_nxt);
         result.release_edges = bel_pkg::WordWidth'(release_nxt);
         result.event_pending = pending_nxt;
      end
   end

endmodule

/* design/bel_checker.sv */
// Port-level checks for the button edge latch, bound to the top level.
`include "button_edge_latch_assert.svh"

module bel_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [bel_pkg::ModeWidth-1:0]    req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bel_pkg::RspDataWidth-1:0] rsp_tdata
);

   logic take_reset_cmd;

   assign take_reset_cmd = req_tvalid && req_tready && (req_tuser == bel_pkg::MODE_RESET);

   // a stalled result word holds
   `BEL_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // the block never stalls the input while the output drains
   `BEL_ASSERT(a_ready_when_drain, (!rsp_tvalid || rsp_tready) |-> req_tready)

   // an accepted word is followed by a valid result word
   `BEL_ASSERT(a_latency, req_tvalid && req_tready |=> ##1 rsp_tvalid)

   // a reset command that moves straight through reports all words cleared
   `BEL_ASSERT(a_reset_cmd, take_reset_cmd ##1 (!rsp_tvalid || rsp_tready) |=> rsp_tdata == '0)

   // no result word is left over after a port reset
   `BEL_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid)

endmodule

bind button_edge_latch bel_checker u_bel_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/button_edge_latch_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the button edge latch: directed and random words against a predictor.
module button_edge_latch_tb;

   localparam logic [bel_pkg::WordWidth-1:0] ButtonMask =
      {bel_pkg::WordWidth{1'b1}} >> (bel_pkg::WordWidth - bel_pkg::NumButtonsDefault);
   localparam int HoldoffCycles = 300;
   localparam int DrainCycles   = 10;
   localparam int RandomWords   = 1080;

   // Button state predictor and queue of expected result words
   class latch_scoreboard;
      logic [bel_pkg::WordWidth-1:0] held;
      logic [bel_pkg::WordWidth-1:0] press_w;
      logic [bel_pkg::WordWidth-1:0] rel_w;
      logic [bel_pkg::WordWidth-1:0] deferred;
      logic [bel_pkg::WordWidth-1:0] synth;
      logic                          pend;
      bel_pkg::result_type           expected_q[$];
      int                            errors;
      int                            checked;

      function new();
         clear_state();
         errors  = 0;
         checked = 0;
      endfunction

      function void clear_state();
         held     = '0;
         press_w  = '0;
         rel_w    = '0;
         deferred = '0;
         synth    = '0;
         pend     = 1'b0;
      endfunction

      // Append one expected result word at the tail
      function void enqueue_expected(bel_pkg::result_type r);
         expected_q.insert(expected_q.size(), r);
      endfunction

      // Releases held back until the press edge has been seen
      function void apply_deferred();
         if (deferred != '0) begin
            rel_w    |= deferred;
            held     &= ~deferred;
            pend      = 1'b1;
            deferred  = '0;
         end
      endfunction

      function void release_bits(logic [bel_pkg::WordWidth-1:0] btns);
         if (btns != '0) begin
            rel_w |= btns;
            held  &= ~btns;
            pend   = 1'b1;
         end
      endfunction

      function void key_update(logic down, logic [bel_pkg::WordWidth-1:0] btn);
         if (down) begin
            deferred &= ~btn;
            if ((held & btn) == '0) begin
               press_w |= btn;
               pend     = 1'b1;
            end
            rel_w &= ~btn;
            held  |= btn;
         end else if ((held & btn) != '0) begin
            // press not yet read: hold the release back
            if ((press_w & btn) != '0) deferred |= btn;
            else release_bits(btn);
         end
      endfunction

      function bel_pkg::result_type snapshot();
         bel_pkg::result_type r;
         r.status_bits   = held;
         r.press_edges   = press_w;
         r.release_edges = rel_w;
         r.event_pending = pend;
         return r;
      endfunction

      // Accepted input word: update state and queue the expected result
      function void note_input(bel_pkg::mode_type op, logic [bel_pkg::IndexWidth-1:0] idx,
                               logic down);
         logic [bel_pkg::WordWidth-1:0] btn;
         bel_pkg::result_type           prior;
         btn   = (bel_pkg::WordWidth'(1) << idx) & ButtonMask;
         prior = snapshot();
         case (op)
            bel_pkg::MODE_KEY: begin
               if (btn != '0) key_update(down, btn);
            end
            bel_pkg::MODE_SYNTHETIC: begin
               if (btn != '0) begin
                  if (down) synth |= btn;
                  else synth &= ~btn;
                  key_update(down, btn);
               end
            end
            bel_pkg::MODE_READ_STAT: begin
               press_w = '0;
               rel_w   = '0;
               apply_deferred();
            end
            bel_pkg::MODE_READ_KEY: begin
               apply_deferred();
            end
            bel_pkg::MODE_READ_PEND: begin
               pend = 1'b0;
            end
            bel_pkg::MODE_CLEAR_ALL: begin
               deferred = '0;
               release_bits(held);
            end
            bel_pkg::MODE_CLEAR_SYN: begin
               btn   = synth & held;
               synth = '0;
               release_bits(btn);
            end
            default: begin
               clear_state();
            end
         endcase
         // reads report the words as they were before the access
         if (op == bel_pkg::MODE_READ_STAT || op == bel_pkg::MODE_READ_KEY ||
             op == bel_pkg::MODE_READ_PEND)
            enqueue_expected(prior);
         else
            enqueue_expected(snapshot());
      endfunction

      function void compare_field(string name, logic [bel_pkg::WordWidth-1:0] exp_v,
                                  logic [bel_pkg::WordWidth-1:0] act_v);
         if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Accepted result word: compare with the oldest expectation
      function void check_result(logic [bel_pkg::RspDataWidth-1:0] data);
         bel_pkg::result_type got;
         bel_pkg::result_type want;
         got = data[bel_pkg::ResultWidth-1:0];
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("status_bits", want.status_bits, got.status_bits);
         compare_field("press_edges", want.press_edges, got.press_edges);
         compare_field("release_edges", want.release_edges, got.release_edges);
         compare_field("event_pending", bel_pkg::WordWidth'(want.event_pending),
                       bel_pkg::WordWidth'(got.event_pending));
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bel_pkg::ReqDataWidth-1:0] req_tdata = '0;   // [4:0] control_index, [5] key_down
   logic [bel_pkg::ModeWidth-1:0]    req_tuser = '0;   // [2:0] mode
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bel_pkg::RspDataWidth-1:0] rsp_tdata;        // [31:0] status, [63:32] press,
                                                       // [95:64] release, [96] pending

   latch_scoreboard sb = new();

   int items_sent     = 0;
   int burst_left     = 1;
   bit tight          = 1'b0;
   int holdoff_wanted = 0;
   int holdoffs_done  = 0;
   int mode_seen[8];

   button_edge_latch u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Offer one word, wait for the handshake, then pace the next one
   task automatic drive_word(bel_pkg::mode_type op, logic [bel_pkg::IndexWidth-1:0] idx,
                             logic down);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= bel_pkg::ReqDataWidth'({down, idx});
      do @(posedge clock); while (!req_tready);
      sb.note_input(op, idx, down);
      mode_seen[op]++;
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if (tight || $urandom_range(0, 3) == 0) gap = 0;
         else gap = $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Mostly events on a few buttons so presses, releases and reads interleave
   task automatic random_word();
      int                             pick;
      bel_pkg::mode_type              op;
      logic [bel_pkg::IndexWidth-1:0] idx;
      logic                           down;
      pick = $urandom_range(0, 99);
      if (pick < 42)      op = bel_pkg::MODE_KEY;
      else if (pick < 58) op = bel_pkg::MODE_SYNTHETIC;
      else if (pick < 72) op = bel_pkg::MODE_READ_STAT;
      else if (pick < 80) op = bel_pkg::MODE_READ_KEY;
      else if (pick < 88) op = bel_pkg::MODE_READ_PEND;
      else if (pick < 93) op = bel_pkg::MODE_CLEAR_ALL;
      else if (pick < 98) op = bel_pkg::MODE_CLEAR_SYN;
      else                op = bel_pkg::MODE_RESET;
      if ($urandom_range(0, 9) < 7) idx = $urandom_range(0, 3);
      else idx = $urandom_range(0, 31);
      down = $urandom_range(0, 1);
      drive_word(op, idx, down);
   endtask

   // Stimulus
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty read, extreme indexes, deferred release, clears, reset
      // (every index is a valid button at 32 buttons, so no index selects nothing)
      drive_word(bel_pkg::MODE_READ_PEND, 5'd0, 1'b0);
      drive_word(bel_pkg::MODE_KEY, 5'd0, 1'b1);
      drive_word(bel_pkg::MODE_KEY, 5'd31, 1'b1);
      drive_word(bel_pkg::MODE_KEY, 5'd31, 1'b0);        // press unread: deferred
      drive_word(bel_pkg::MODE_READ_KEY, 5'd0, 1'b0);    // applies it
      drive_word(bel_pkg::MODE_READ_STAT, 5'd0, 1'b0);
      drive_word(bel_pkg::MODE_KEY, 5'd0, 1'b1);         // already held
      drive_word(bel_pkg::MODE_KEY, 5'd0, 1'b0);         // press was read: released now
      drive_word(bel_pkg::MODE_KEY, 5'd7, 1'b0);         // not held
      drive_word(bel_pkg::MODE_SYNTHETIC, 5'd3, 1'b1);
      drive_word(bel_pkg::MODE_SYNTHETIC, 5'd31, 1'b1);
      drive_word(bel_pkg::MODE_KEY, 5'd10, 1'b1);
      drive_word(bel_pkg::MODE_SYNTHETIC, 5'd3, 1'b0);
      drive_word(bel_pkg::MODE_READ_PEND, 5'd31, 1'b1);
      drive_word(bel_pkg::MODE_CLEAR_SYN, 5'd0, 1'b0);
      drive_word(bel_pkg::MODE_READ_STAT, 5'd0, 1'b0);
      drive_word(bel_pkg::MODE_KEY, 5'd20, 1'b1);
      drive_word(bel_pkg::MODE_KEY, 5'd20, 1'b0);
      drive_word(bel_pkg::MODE_CLEAR_ALL, 5'd0, 1'b0);   // drops the deferred release
      drive_word(bel_pkg::MODE_READ_STAT, 5'd0, 1'b0);
      drive_word(bel_pkg::MODE_SYNTHETIC, 5'd12, 1'b0);
      drive_word(bel_pkg::MODE_KEY, 5'd5, 1'b1);
      drive_word(bel_pkg::MODE_RESET, 5'd31, 1'b1);
      drive_word(bel_pkg::MODE_READ_STAT, 5'd0, 1'b0);
      drive_word(bel_pkg::MODE_READ_PEND, 5'd0, 1'b0);

      // random: two back-to-back bursts against a long receiver hold-off,
      // and one gap-free stretch
      for (int i = 0; i < RandomWords; i++) begin
         if (i == 300 || i == 750) begin
            holdoff_wanted <= holdoff_wanted + 1;
            tight = 1'b1;
         end
         if (i == 500) tight = 1'b1;
         if (i == 340 || i == 560 || i == 790) tight = 1'b0;
         random_word();
      end
      req_tvalid <= 1'b0;

      // drain
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d words, checked %0d results, %0d receiver hold-offs.",
               items_sent, sb.checked, holdoffs_done);
      $display("Per mode: key %0d syn %0d stat %0d rkey %0d pend %0d clr %0d csyn %0d rst %0d",
               mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
               mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7]);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Receiver: check accepted results, stall on changing patterns
   initial begin
      int pattern;
      int pattern_left;
      int hold_left;
      pattern      = 0;
      pattern_left = 0;
      hold_left    = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (holdoffs_done < holdoff_wanted) begin
            hold_left = HoldoffCycles;
            holdoffs_done++;
         end
         if (pattern_left == 0) begin
            pattern      = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 150);
         end
         pattern_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (pattern)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("Timeout with %0d results outstanding", sb.expected_q.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/bel_pkg.sv
design/bel_update.sv
design/button_edge_latch.sv
design/bel_checker.sv
tb/button_edge_latch_tb.sv
